// ----- hdl/vec3_reflect_keep_length_unit_assert.svh -----
// ----------------------------------------------------------------------------
// vec3 reflect assertion macros
// Shared concurrent assertion forms, clocked on clk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef VEC3_REFLECT_KEEP_LENGTH_UNIT_ASSERT_SVH
`define VEC3_REFLECT_KEEP_LENGTH_UNIT_ASSERT_SVH

// same-cycle implication
`define VRKL_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define VRKL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/vrkl_pkg.sv -----
// ----------------------------------------------------------------------------
// vrkl_pkg
// Constants, sideband types and helpers for the vector reflection pipeline.
// ----------------------------------------------------------------------------
package vrkl_pkg;

  localparam int FRAC_BITS = 16;
  localparam int UNIT_BITS = 30;
  localparam int SQRT_LAT  = 32;
  localparam int DIV_LAT   = 32;
  localparam int PIPE_LAT  = 3 + SQRT_LAT + 1 + DIV_LAT + 12 + SQRT_LAT + 1 + DIV_LAT + 1;

  // lengths at or below this are treated as zero (1e-6 in the fixed format truncates to 0)
  localparam logic [31:0] EPS_LIM = 32'((64'd1 << FRAC_BITS) / 64'd1000000);

  localparam int D_W  = 64 - UNIT_BITS + 1;
  localparam int DH_W = D_W - FRAC_BITS;
  localparam int PR_W = 68;

  typedef struct packed {
    logic [2:0]       neg;
    logic [2:0][31:0] mag;
    logic [2:0][31:0] nrm;
  } vrkl_sb1_t;

  typedef struct packed {
    logic [2:0]       neg;
    logic [2:0][31:0] nrm;
    logic [31:0]      len;
    logic             ok;
  } vrkl_sb2_t;

  typedef struct packed {
    logic [2:0][31:0] u;
    logic [2:0][31:0] nrm;
    logic [31:0]      len;
  } vrkl_sb3_t;

  typedef struct packed {
    logic [2:0][29:0] ws;
    logic [2:0]       wneg;
    logic             snz;
    logic [31:0]      len;
  } vrkl_sb4_t;

  typedef struct packed {
    logic [2:0] wneg;
    logic       ok;
  } vrkl_sb5_t;

  function automatic logic [3:0] bitlen8(input logic [7:0] v);
    logic [3:0] r;
    r = '0;
    for (int i = 0; i < 8; i++) begin
      if (v[i]) r = 4'(i + 1);
    end
    return r;
  endfunction

endpackage

// ----- hdl/vrkl_sqrt.sv -----
// ----------------------------------------------------------------------------
// vrkl_sqrt
// Pipelined integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
module vrkl_sqrt (
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] rad,
  output logic [31:0] root
);
  import vrkl_pkg::*;

  logic [32:0] rem_r   [SQRT_LAT];
  logic [31:0] root_r  [SQRT_LAT];
  logic [63:0] xs_r    [SQRT_LAT];
  logic [32:0] rem_nxt [SQRT_LAT];
  logic [31:0] root_nxt[SQRT_LAT];
  logic [63:0] xs_nxt  [SQRT_LAT];

  always_comb begin
    logic [32:0] prem;
    logic [31:0] proot;
    logic [63:0] pxs;
    logic [34:0] re;
    logic [34:0] trial;
    for (int k = 0; k < SQRT_LAT; k++) begin
      prem  = (k == 0) ? '0 : rem_r[(k == 0) ? 0 : k - 1];
      proot = (k == 0) ? '0 : root_r[(k == 0) ? 0 : k - 1];
      pxs   = (k == 0) ? rad : xs_r[(k == 0) ? 0 : k - 1];
      re    = {prem[32:0], pxs[63:62]};
      trial = {1'b0, proot, 2'b01};
      xs_nxt[k] = {pxs[61:0], 2'b00};
      if (re >= trial) begin
        rem_nxt[k]  = 33'(re - trial);
        root_nxt[k] = {proot[30:0], 1'b1};
      end else begin
        rem_nxt[k]  = re[32:0];
        root_nxt[k] = {proot[30:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < SQRT_LAT; k++) begin
        rem_r[k]  <= rem_nxt[k];
        root_r[k] <= root_nxt[k];
        xs_r[k]   <= xs_nxt[k];
      end
    end
  end

  assign root = root_r[SQRT_LAT-1];

endmodule

// ----- hdl/vrkl_div.sv -----
// ----------------------------------------------------------------------------
// vrkl_div
// Pipelined restoring divider, 64 by 32 bits, 32-bit quotient, one bit a stage.
// ----------------------------------------------------------------------------
module vrkl_div (
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] num,
  input  logic [31:0] den,
  output logic [31:0] quo
);
  import vrkl_pkg::*;

  // quotient must fit in 32 bits: num < den * 2^32
  logic [31:0] rem_r  [DIV_LAT];
  logic [31:0] low_r  [DIV_LAT];
  logic [31:0] quo_r  [DIV_LAT];
  logic [31:0] den_r  [DIV_LAT];
  logic [31:0] rem_nxt[DIV_LAT];
  logic [31:0] low_nxt[DIV_LAT];
  logic [31:0] quo_nxt[DIV_LAT];
  logic [31:0] den_nxt[DIV_LAT];

  always_comb begin
    logic [31:0] prem;
    logic [31:0] plow;
    logic [31:0] pquo;
    logic [31:0] pden;
    logic [32:0] t;
    for (int k = 0; k < DIV_LAT; k++) begin
      prem = (k == 0) ? num[63:32] : rem_r[(k == 0) ? 0 : k - 1];
      plow = (k == 0) ? num[31:0]  : low_r[(k == 0) ? 0 : k - 1];
      pquo = (k == 0) ? '0         : quo_r[(k == 0) ? 0 : k - 1];
      pden = (k == 0) ? den        : den_r[(k == 0) ? 0 : k - 1];
      t = {prem, plow[31]};
      low_nxt[k] = {plow[30:0], 1'b0};
      den_nxt[k] = pden;
      if (t >= {1'b0, pden}) begin
        rem_nxt[k] = 32'(t - {1'b0, pden});
        quo_nxt[k] = {pquo[30:0], 1'b1};
      end else begin
        rem_nxt[k] = t[31:0];
        quo_nxt[k] = {pquo[30:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < DIV_LAT; k++) begin
        rem_r[k] <= rem_nxt[k];
        low_r[k] <= low_nxt[k];
        quo_r[k] <= quo_nxt[k];
        den_r[k] <= den_nxt[k];
      end
    end
  end

  assign quo = quo_r[DIV_LAT-1];

endmodule

// ----- hdl/vec3_reflect_keep_length_unit.sv -----
// ----------------------------------------------------------------------------
// vec3_reflect_keep_length_unit
// Reflects a Q16.16 vector about a surface normal, keeping its length.
// ----------------------------------------------------------------------------
// Usage:
//   Input request: in_x/y/z (incoming vector) and in_normal_x/y/z (normal, used
//   as given), taken when in_valid is high and in_stall is low.
//   Result request: out_x/y/z, taken when out_valid is high and out_stall low.
//   Each request gives exactly one result, in order.
// Timing:
//   Fully pipelined; one request per cycle sustained while in_stall is low.
//   The pipe holds two 32-stage square roots and two banks of three
//   32-stage dividers, one bit per stage, and ends in the output register.
// Reset and stall:
//   rst_n (synchronous) empties the pipe and the output. When the receiver
//   stalls, the pipe keeps running until the output register and one skid
//   register are full; only then is in_stall raised. Nothing is dropped
//   or repeated.
// ----------------------------------------------------------------------------
`include "vec3_reflect_keep_length_unit_assert.svh"

module vec3_reflect_keep_length_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] in_x,
  input  logic signed [31:0] in_y,
  input  logic signed [31:0] in_z,
  input  logic signed [31:0] in_normal_x,
  input  logic signed [31:0] in_normal_y,
  input  logic signed [31:0] in_normal_z,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_x,
  output logic signed [31:0] out_y,
  output logic signed [31:0] out_z
);
  import vrkl_pkg::*;

  logic                en;
  logic [PIPE_LAT-1:0] vld_r;
  logic                out_vld_r;
  logic                skid_vld_r;
  logic [2:0][31:0]    out_r;
  logic [2:0][31:0]    skid_r;
  logic [2:0][31:0]    z_res_r;

  logic signed [31:0] vin [3];
  logic signed [31:0] nin [3];

  assign vin[0] = in_x;
  assign vin[1] = in_y;
  assign vin[2] = in_z;
  assign nin[0] = in_normal_x;
  assign nin[1] = in_normal_y;
  assign nin[2] = in_normal_z;

  // the pipe only halts once the skid register holds a result
  assign en = !skid_vld_r;

  // ---------------- length of the incoming vector ----------------
  vrkl_sb1_t   a_sb_r, b_sb_r, c_sb_r;
  vrkl_sb1_t   sb1_r [SQRT_LAT];
  logic [63:0] b_sq_r [3];
  logic [63:0] c_sum_r;
  logic [31:0] len;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        a_sb_r.neg[i] <= vin[i][31];
        a_sb_r.mag[i] <= vin[i][31] ? 32'(-vin[i]) : vin[i];
        a_sb_r.nrm[i] <= nin[i];
        b_sq_r[i]     <= {32'd0, a_sb_r.mag[i]} * {32'd0, a_sb_r.mag[i]};
      end
      b_sb_r  <= a_sb_r;
      c_sum_r <= b_sq_r[0] + b_sq_r[1] + b_sq_r[2];
      c_sb_r  <= b_sb_r;
      sb1_r[0] <= c_sb_r;
      for (int k = 1; k < SQRT_LAT; k++) sb1_r[k] <= sb1_r[k-1];
    end
  end

  vrkl_sqrt u_sqrt_len (
    .clk  (clk),
    .en   (en),
    .rad  (c_sum_r),
    .root (len)
  );

  // ---------------- unit vector u = -in / len ----------------
  vrkl_sb2_t   e_sb_r;
  vrkl_sb2_t   sb2_r [DIV_LAT];
  logic [31:0] e_mag_r [3];
  logic [31:0] q1 [3];

  always_ff @(posedge clk) begin
    if (en) begin
      e_sb_r.neg <= sb1_r[SQRT_LAT-1].neg;
      e_sb_r.nrm <= sb1_r[SQRT_LAT-1].nrm;
      e_sb_r.len <= len;
      // the limit is zero, so only a zero length falls under it
      e_sb_r.ok  <= len > EPS_LIM;
      for (int i = 0; i < 3; i++) e_mag_r[i] <= sb1_r[SQRT_LAT-1].mag[i];
      sb2_r[0] <= e_sb_r;
      for (int k = 1; k < DIV_LAT; k++) sb2_r[k] <= sb2_r[k-1];
    end
  end

  for (genvar g = 0; g < 3; g++) begin : g_div_u
    vrkl_div u_div (
      .clk (clk),
      .en  (en),
      .num (64'(e_mag_r[g]) << UNIT_BITS),
      .den (e_sb_r.len),
      .quo (q1[g])
    );
  end

  // ---------------- d = 2*dot(u, n), w = n*d - u ----------------
  vrkl_sb3_t                u_sb_r, p_sb_r, d_sb_r, h_sb_r, r_sb_r;
  logic signed [63:0]       p_np_r [3];
  logic signed [63:0]       d_dot_r;
  logic signed [D_W-1:0]    d_val;
  logic signed [DH_W-1:0]   d_hi;
  logic [FRAC_BITS-1:0]     d_lo;
  logic signed [31+DH_W:0]  h_ph_r [3];
  logic signed [32+FRAC_BITS:0] h_pl_r [3];
  logic signed [PR_W-1:0]   r_pr_r [3];
  logic signed [63:0]       w_w_r [3];
  logic [31:0]              w_len_r;

  assign d_val = d_dot_r[63:UNIT_BITS-1];
  assign d_hi  = d_val[D_W-1:FRAC_BITS];
  assign d_lo  = d_val[FRAC_BITS-1:0];

  always_ff @(posedge clk) begin
    logic signed [PR_W-1:0] pr_sh;
    logic signed [PR_W-1:0] u_sh;
    logic signed [PR_W-1:0] w_full;
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        if (!sb2_r[DIV_LAT-1].ok) begin
          u_sb_r.u[i] <= '0;
        end else if (sb2_r[DIV_LAT-1].neg[i]) begin
          u_sb_r.u[i] <= q1[i];
        end else begin
          u_sb_r.u[i] <= 32'(-q1[i]);
        end
        p_np_r[i] <= $signed(u_sb_r.nrm[i]) * $signed(u_sb_r.u[i]);
        h_ph_r[i] <= $signed(d_sb_r.nrm[i]) * d_hi;
        h_pl_r[i] <= $signed(d_sb_r.nrm[i]) * $signed({1'b0, d_lo});
        r_pr_r[i] <= (PR_W'(h_ph_r[i]) <<< FRAC_BITS) + PR_W'(h_pl_r[i]);
        pr_sh  = r_pr_r[i] >>> FRAC_BITS;
        u_sh   = PR_W'($signed(r_sb_r.u[i])) >>> (UNIT_BITS - FRAC_BITS);
        w_full = pr_sh - u_sh;
        w_w_r[i] <= w_full[63:0];
      end
      u_sb_r.nrm <= sb2_r[DIV_LAT-1].nrm;
      u_sb_r.len <= sb2_r[DIV_LAT-1].len;
      p_sb_r     <= u_sb_r;
      d_dot_r    <= p_np_r[0] + p_np_r[1] + p_np_r[2];
      d_sb_r     <= p_sb_r;
      h_sb_r     <= d_sb_r;
      r_sb_r     <= h_sb_r;
      w_len_r    <= r_sb_r.len;
    end
  end

  // ---------------- scale w below 2^30 and take its length ----------------
  logic [63:0]      m_wm_r [3];
  logic [2:0]       m_wneg_r;
  logic [63:0]      m_or_r;
  logic [31:0]      m_len_r;
  logic [63:0]      g_wm_r [3];
  logic [2:0]       g_wneg_r;
  logic [7:0]       g_cnz_r;
  logic [7:0][3:0]  g_clen_r;
  logic [31:0]      g_len_r;
  logic [63:0]      s_wm_r [3];
  logic [2:0]       s_wneg_r;
  logic [6:0]       s_sh_r;
  logic [31:0]      s_len_r;
  logic [6:0]       bl;
  vrkl_sb4_t        x_sb_r, q_sb_r, t_sb_r;
  vrkl_sb4_t        sb4_r [SQRT_LAT];
  logic [59:0]      q_sq_r [3];
  logic [61:0]      t_sum_r;
  logic [31:0]      m_len2;

  // bit length of the largest magnitude equals that of the OR of all three
  always_comb begin
    bl = '0;
    for (int k = 0; k < 8; k++) begin
      if (g_cnz_r[k]) bl = 7'(8 * k) + 7'(g_clen_r[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        m_wm_r[i]   <= w_w_r[i][63] ? 64'(-w_w_r[i]) : w_w_r[i];
        m_wneg_r[i] <= w_w_r[i][63];
        g_wm_r[i]   <= m_wm_r[i];
        s_wm_r[i]   <= g_wm_r[i];
        x_sb_r.ws[i] <= 30'(s_wm_r[i] >> s_sh_r);
        q_sq_r[i]   <= {30'd0, x_sb_r.ws[i]} * {30'd0, x_sb_r.ws[i]};
      end
      m_or_r  <= 64'(w_w_r[0][63] ? 64'(-w_w_r[0]) : w_w_r[0])
               | 64'(w_w_r[1][63] ? 64'(-w_w_r[1]) : w_w_r[1])
               | 64'(w_w_r[2][63] ? 64'(-w_w_r[2]) : w_w_r[2]);
      m_len_r <= w_len_r;
      for (int k = 0; k < 8; k++) begin
        g_cnz_r[k]  <= |m_or_r[8*k +: 8];
        g_clen_r[k] <= bitlen8(m_or_r[8*k +: 8]);
      end
      g_wneg_r <= m_wneg_r;
      g_len_r  <= m_len_r;
      s_sh_r   <= (bl > 7'(UNIT_BITS)) ? 7'(bl - 7'(UNIT_BITS)) : '0;
      s_wneg_r <= g_wneg_r;
      s_len_r  <= g_len_r;
      x_sb_r.wneg <= s_wneg_r;
      x_sb_r.snz  <= s_sh_r != '0;
      x_sb_r.len  <= s_len_r;
      q_sb_r  <= x_sb_r;
      t_sum_r <= 62'(q_sq_r[0]) + 62'(q_sq_r[1]) + 62'(q_sq_r[2]);
      t_sb_r  <= q_sb_r;
      sb4_r[0] <= t_sb_r;
      for (int k = 1; k < SQRT_LAT; k++) sb4_r[k] <= sb4_r[k-1];
    end
  end

  vrkl_sqrt u_sqrt_w (
    .clk  (clk),
    .en   (en),
    .rad  ({2'b00, t_sum_r}),
    .root (m_len2)
  );

  // ---------------- out = w * len / |w| ----------------
  logic [61:0] k_wl_r [3];
  logic [31:0] k_m_r;
  vrkl_sb5_t   k_sb_r;
  vrkl_sb5_t   sb5_r [DIV_LAT];
  logic [31:0] q2 [3];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        k_wl_r[i] <= {32'd0, sb4_r[SQRT_LAT-1].ws[i]} * {30'd0, sb4_r[SQRT_LAT-1].len};
      end
      k_m_r       <= m_len2;
      k_sb_r.wneg <= sb4_r[SQRT_LAT-1].wneg;
      // a shifted w is always long enough
      k_sb_r.ok   <= sb4_r[SQRT_LAT-1].snz || (m_len2 > EPS_LIM);
      sb5_r[0] <= k_sb_r;
      for (int k = 1; k < DIV_LAT; k++) sb5_r[k] <= sb5_r[k-1];
    end
  end

  for (genvar g = 0; g < 3; g++) begin : g_div_o
    vrkl_div u_div (
      .clk (clk),
      .en  (en),
      .num ({2'b00, k_wl_r[g]}),
      .den (k_m_r),
      .quo (q2[g])
    );
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        if (!sb5_r[DIV_LAT-1].ok) begin
          z_res_r[i] <= '0;
        end else if (sb5_r[DIV_LAT-1].wneg[i]) begin
          z_res_r[i] <= (q2[i] > 32'h8000_0000) ? 32'h8000_0000 : 32'(-q2[i]);
        end else begin
          z_res_r[i] <= (q2[i] > 32'h7FFF_FFFF) ? 32'h7FFF_FFFF : q2[i];
        end
      end
    end
  end

  // ---------------- valid tracking, output and skid registers ----------------
  logic pipe_out;
  logic out_take;

  assign pipe_out = en && vld_r[PIPE_LAT-1];
  assign out_take = out_vld_r && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r      <= '0;
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      if (en) vld_r <= {vld_r[PIPE_LAT-2:0], in_valid};
      if (skid_vld_r) begin
        if (out_take) skid_vld_r <= 1'b0;
      end else if (pipe_out) begin
        if (!out_vld_r || out_take) begin
          out_vld_r <= 1'b1;
        end else begin
          skid_vld_r <= 1'b1;
        end
      end else if (out_take) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (skid_vld_r) begin
      if (out_take) out_r <= skid_r;
    end else if (pipe_out) begin
      if (!out_vld_r || out_take) begin
        out_r <= z_res_r;
      end else begin
        skid_r <= z_res_r;
      end
    end
  end

  assign in_stall  = skid_vld_r;
  assign out_valid = out_vld_r;
  assign out_x     = out_r[0];
  assign out_y     = out_r[1];
  assign out_z     = out_r[2];

  `VRKL_ASSERT_NOW(a_skid_needs_out, skid_vld_r, out_vld_r, "skid full with empty output")
  `VRKL_ASSERT_NEXT(a_skid_fill, !skid_vld_r && pipe_out && out_vld_r && out_stall, skid_vld_r, "result lost on stall")
  `VRKL_ASSERT_NEXT(a_skid_drain, skid_vld_r && !out_stall, !skid_vld_r && out_vld_r, "skid not drained")

endmodule
